[rtl/dprr_pkg.sv]
// ----------------------------------------------------------------------------
// dprr_pkg
// Shared types and constants for the delimited packet ring receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dprr_pkg;

  localparam int RING_DEPTH_DEF  = 256;
  localparam int MAX_PAYLOAD_DEF = 19;

  localparam logic [7:0] START_MARK = 8'h3C;  // '<'
  localparam logic [7:0] END_MARK   = 8'h3E;  // '>'

  // request operations
  localparam logic [1:0] OP_RECV = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_ERR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_NOPKT    = 3'd1;
  localparam logic [2:0] ST_BADSTART = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_byte;
    logic       last;
    logic [7:0] packet_count;
    logic       error_flag;
  } out_res_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic     valid;
    out_res_t res;
  } emit_t;

endpackage

`default_nettype wire

[rtl/dprr_stream_if.sv]
// ----------------------------------------------------------------------------
// dprr_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dprr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/dprr_ram.sv]
// ----------------------------------------------------------------------------
// dprr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/dprr_ctrl.sv]
// ----------------------------------------------------------------------------
// dprr_ctrl
// Framing logic and packet read sequencer around the byte ring.
// ----------------------------------------------------------------------------
`default_nettype none

module dprr_ctrl #(
  parameter int RING_DEPTH  = dprr_pkg::RING_DEPTH_DEF,
  parameter int MAX_PAYLOAD = dprr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  dprr_stream_if.sink                        in_req,
  input  wire logic                          out_free,
  output dprr_pkg::emit_t                    emit,
  output logic                               ram_we,
  output logic [$clog2(RING_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                         ram_wdata,
  output logic [$clog2(RING_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                    ram_rdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W = (OCC_W > 8) ? OCC_W : 8;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_STAT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               inside_r, inside_nxt;
  logic               err_r, err_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [7:0]         hold_r, hold_nxt;
  logic [2:0]         stat_code_r, stat_code_nxt;
  logic               stat_err_r, stat_err_nxt;

  logic               accept;
  logic               room;
  logic               scan_more;
  dprr_pkg::in_req_t  req;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign req          = in_req.data;
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  // a '<' or payload byte must leave one slot free for the closing '>'
  assign room = ((OCC_W+1)'(occ_r) + (OCC_W+1)'(2)) <= (OCC_W+1)'(RING_DEPTH);

  assign scan_more = (n_r < LEN_W'(MAX_PAYLOAD)) && (occ_r != '0) &&
                     (ram_rdata != dprr_pkg::END_MARK);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    inside_nxt    = inside_r;
    err_nxt       = err_r;
    plen_nxt      = plen_r;
    n_nxt         = n_r;
    hold_nxt      = hold_r;
    stat_code_nxt = stat_code_r;
    stat_err_nxt  = stat_err_r;
    ram_we        = 1'b0;
    ram_wdata     = req.rx_byte;
    emit          = '0;
    emit.res.packet_count = cnt_r[7:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            dprr_pkg::OP_RECV: begin
              if (req.rx_byte == dprr_pkg::START_MARK) begin
                if (inside_r || !room) begin
                  err_nxt = 1'b1;
                end else begin
                  ram_we     = 1'b1;
                  inside_nxt = 1'b1;
                  plen_nxt   = '0;
                end
              end else if (req.rx_byte == dprr_pkg::END_MARK) begin
                if (!inside_r) begin
                  err_nxt = 1'b1;
                end else begin
                  ram_we     = 1'b1;
                  cnt_nxt    = cnt_r + 1'b1;
                  inside_nxt = 1'b0;
                  plen_nxt   = '0;
                end
              end else begin
                if (!inside_r || !room || plen_r >= LEN_W'(MAX_PAYLOAD)) begin
                  err_nxt = 1'b1;
                end else begin
                  ram_we   = 1'b1;
                  plen_nxt = plen_r + 1'b1;
                end
              end
              if (ram_we) begin
                wp_nxt  = adv(wp_r);
                occ_nxt = occ_r + 1'b1;
              end
            end
            dprr_pkg::OP_GET: begin
              if (cnt_r == '0 || occ_r == '0) begin
                stat_code_nxt = dprr_pkg::ST_NOPKT;
                stat_err_nxt  = 1'b0;
                state_nxt     = S_STAT;
              end else begin
                state_nxt = S_HEAD;
              end
            end
            dprr_pkg::OP_ERR: begin
              stat_code_nxt = dprr_pkg::ST_ERROR;
              stat_err_nxt  = err_r;
              err_nxt       = 1'b0;
              state_nxt     = S_STAT;
            end
            default: ;
          endcase
        end
      end

      S_HEAD: begin
        // ring data now holds the oldest byte
        rp_nxt  = adv(rp_r);
        occ_nxt = occ_r - 1'b1;
        if (ram_rdata != dprr_pkg::START_MARK) begin
          stat_code_nxt = dprr_pkg::ST_BADSTART;
          stat_err_nxt  = 1'b0;
          state_nxt     = S_STAT;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          n_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // hold_r keeps the previous payload byte until the next byte shows
        // whether it was the final one
        if (scan_more) begin
          if (n_r != '0) begin
            emit.valid         = 1'b1;
            emit.res.status    = dprr_pkg::ST_DATA;
            emit.res.data_byte = hold_r;
          end
          if (n_r == '0 || out_free) begin
            rp_nxt   = adv(rp_r);
            occ_nxt  = occ_r - 1'b1;
            n_nxt    = n_r + 1'b1;
            hold_nxt = ram_rdata;
          end
        end else begin
          if (n_r != '0) begin
            emit.valid         = 1'b1;
            emit.res.status    = dprr_pkg::ST_DATA;
            emit.res.data_byte = hold_r;
            emit.res.last      = 1'b1;
          end
          if (n_r == '0 || out_free) begin
            if (occ_r != '0 && ram_rdata == dprr_pkg::END_MARK) begin
              rp_nxt  = adv(rp_r);
              occ_nxt = occ_r - 1'b1;
            end
            if (n_r == '0) begin
              stat_code_nxt = dprr_pkg::ST_EMPTY;
              stat_err_nxt  = 1'b0;
              state_nxt     = S_STAT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_STAT: begin
        emit.valid          = 1'b1;
        emit.res.status     = stat_code_r;
        emit.res.last       = 1'b1;
        emit.res.error_flag = stat_err_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_waddr = wp_r;
  // read address follows the next read pointer so the registered read data
  // always holds the byte at rp_r
  assign ram_raddr = rp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      occ_r    <= '0;
      cnt_r    <= '0;
      inside_r <= 1'b0;
      err_r    <= 1'b0;
      plen_r   <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      occ_r    <= occ_nxt;
      cnt_r    <= cnt_nxt;
      inside_r <= inside_nxt;
      err_r    <= err_nxt;
      plen_r   <= plen_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r      <= hold_nxt;
    stat_code_r <= stat_code_nxt;
    stat_err_r  <= stat_err_nxt;
  end

  // pointer consistency: write pointer sits occupancy entries past read pointer
  logic [PTR_W:0] rp_plus_occ;
  logic [PTR_W:0] wp_expect;

  assign rp_plus_occ = (PTR_W+1)'(rp_r) + (PTR_W+1)'(occ_r);
  assign wp_expect   = (rp_plus_occ >= (PTR_W+1)'(RING_DEPTH)) ?
                       rp_plus_occ - (PTR_W+1)'(RING_DEPTH) : rp_plus_occ;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(RING_DEPTH))
    else $error("ring occupancy beyond depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != OCC_W'(RING_DEPTH)) |-> (wp_expect == (PTR_W+1)'(wp_r)))
    else $error("ring pointers and occupancy disagree");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ram_we)
    else $error("ring written during a packet read");

  a_good_start_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD && ram_rdata == dprr_pkg::START_MARK) |=>
      (cnt_r == $past(cnt_r) - 1'b1))
    else $error("packet count not decremented on packet read");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (n_r <= LEN_W'(MAX_PAYLOAD)))
    else $error("payload scan ran past maximum length");

endmodule

`default_nettype wire

[rtl/delimited_packet_ring_receiver.sv]
// ----------------------------------------------------------------------------
// delimited_packet_ring_receiver
// Framed byte receiver with a packet ring and a registered result port.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A received byte (and an unused
// operation code) leaves the sequencer idle, so the next request may follow
// at once. Read-error sends one status result. Get-packet checks the start
// mark, then sends the payload; an empty packet, a bad start or no waiting
// packet yields a status result. The ring has one registered read port; the
// sequencer consumes one ring byte per cycle while the result port is free,
// one byte ahead of the payload result it sends. A stalled result port holds
// the sequencer; receive requests are still taken while the last result waits.
`default_nettype none

module delimited_packet_ring_receiver #(
  parameter int RING_DEPTH  = dprr_pkg::RING_DEPTH_DEF,
  parameter int MAX_PAYLOAD = dprr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  dprr_stream_if.sink   in_req,
  dprr_stream_if.source out_res
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  dprr_pkg::emit_t    emit;
  logic               out_free;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [7:0]         ram_wdata;
  logic [PTR_W-1:0]   ram_raddr;
  logic [7:0]         ram_rdata;

  logic               out_valid_r, out_valid_nxt;
  dprr_pkg::out_res_t out_data_r;

  dprr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  dprr_ctrl #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_free  (out_free),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register takes a new result when empty or being drained
  assign out_free = !out_valid_r || out_res.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && out_free) begin
      out_data_r <= emit.res;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready && emit.valid) |=> $stable(out_data_r))
    else $error("result register overwritten while stalled");

  a_status_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != dprr_pkg::ST_DATA) |->
      (out_data_r.data_byte == 8'd0 && out_data_r.last))
    else $error("status result carries data or lacks last mark");

  a_err_only_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error_flag) |->
      (out_data_r.status == dprr_pkg::ST_ERROR))
    else $error("error flag set outside an error report");

endmodule

`default_nettype wire
